// ===== hdl/orec_pkg.sv =====
// Shared types and constants for the optimal-replacement eviction counter.
// Holds field widths and the control word that the sequencer sends to every slot cell.
// No dependencies.
package orec_pkg;

    localparam int ID_W  = 8;   // item id width
    localparam int CNT_W = 11;  // eviction count width
    localparam int CFG_W = 5;   // slot count register width

    // Control word broadcast from the sequencer to the slot cells
    typedef struct packed {
        logic              restart;    // empty every slot for a new replay
        logic              scan_en;    // scan_id holds a future request
        logic              fill_en;    // place cur_id in the slot at fill_idx
        logic              evict_go;   // replace the victim with cur_id now
        logic              all_found;  // every live slot has a next use
        logic [ID_W-1:0]   scan_id;    // future request under scan
        logic [ID_W-1:0]   cur_id;     // request being placed
    } cell_ctl_t;

    // Status of one slot cell
    typedef struct packed {
        logic hit;    // slot holds cur_id
        logic open;   // slot is live and its next use is still unknown
    } cell_sts_t;

endpackage

// ===== hdl/orec_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Parameters set word width and depth; no package dependencies.
module orec_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/orec_cell.sv =====
// One slot of the simulated store: holds an id, a live bit and a next-use-found bit.
// Hands the victim token to its neighbor; uses orec_pkg for the control and status types.
module orec_cell #(
    parameter int SW  = 5,
    parameter int IDX = 0
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  orec_pkg::cell_ctl_t  ctl,
    input  logic [SW-1:0]        fill_idx,
    input  logic                 claim_in,
    output logic                 claim_out,
    output orec_pkg::cell_sts_t  sts
);

    logic                      valid_reg, valid_next;
    logic                      found_reg, found_next;
    logic [orec_pkg::ID_W-1:0] id_reg, id_next;
    logic                      match;
    logic                      open;
    logic                      fill;
    logic                      take;

    // Compare against the scanned request and the request being placed
    always_comb
    begin
        match      = valid_reg & ~found_reg & ctl.scan_en & (id_reg == ctl.scan_id);
        found_next = found_reg | match;
        open       = valid_reg & ~found_next;
        claim_out  = claim_in & ~open;
        fill       = ctl.fill_en & (fill_idx == SW'(IDX));
        take       = ctl.evict_go & (ctl.all_found ? match : (claim_in & open));
        sts.hit    = valid_reg & (id_reg == ctl.cur_id);
        sts.open   = open;
    end

    // Next state of the slot
    always_comb
    begin
        valid_next = valid_reg;
        id_next    = id_reg;
        if (ctl.restart)
        begin
            valid_next = 1'b0;
        end
        else if (fill)
        begin
            valid_next = 1'b1;
        end
        if (fill || take)
        begin
            id_next = ctl.cur_id;
        end
    end

    // Hold live and found flags; drop found after every eviction and on restart
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            found_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            found_reg <= (ctl.restart || ctl.evict_go) ? 1'b0 : found_next;
        end
    end

    // Slot id payload
    always_ff @(posedge clk)
    begin
        id_reg <= id_next;
    end

endmodule

// ===== hdl/optimal_replacement_eviction_counter.sv =====
// Top level of the optimal-replacement eviction counter: sequencer, request RAM, slot chain.
// Depends on orec_pkg, orec_ram and orec_cell.
//
// Requests load at one per cycle into a RAM of SEQ_DEPTH entries; the request marked last
// starts a replay against slot_count slots (0 acts as 1, values above MAX_SLOTS as MAX_SLOTS),
// held in a row of MAX_SLOTS cells. During replay each request is read from the RAM, then checked
// for a hit or filled. A request that evicts also scans the later requests, one RAM read
// per cycle, until every slot's next use is found or the sequence ends; the data of the first
// look-ahead read comes from the registered RAM read port before it can be compared. The
// input stalls from the final request until the count is placed in the output register.
// Requests beyond SEQ_DEPTH are dropped and flagged in overflow.
module optimal_replacement_eviction_counter #(
    parameter int SEQ_DEPTH = 1024,
    parameter int MAX_SLOTS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [orec_pkg::CFG_W-1:0]  cfg_data,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [orec_pkg::ID_W-1:0]   item_id,
    input  logic                        last,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [orec_pkg::CNT_W-1:0]  eviction_count,
    output logic                        overflow
);

    localparam int LW = $clog2(SEQ_DEPTH + 1);
    localparam int AW = $clog2(SEQ_DEPTH);
    localparam int SW = $clog2(MAX_SLOTS + 1);

    typedef enum logic [2:0] {
        S_LOAD,
        S_FETCH,
        S_CHECK,
        S_SCAN,
        S_DONE
    } state_t;

    state_t                       state_reg, state_next;
    logic [orec_pkg::CFG_W-1:0]   cfg_reg;
    logic [LW-1:0]                len_reg, len_next;
    logic                         ovf_reg, ovf_next;
    logic [LW-1:0]                idx_reg, idx_next;
    logic [LW-1:0]                ja_reg, ja_next;
    logic                         dv_reg, dv_next;
    logic                         dl_reg, dl_next;
    logic [SW-1:0]                filled_reg, filled_next;
    logic [orec_pkg::CNT_W-1:0]   evict_reg, evict_next;
    logic [orec_pkg::ID_W-1:0]    cur_reg, cur_next;
    logic                         out_valid_reg, out_valid_next;
    logic [orec_pkg::CNT_W-1:0]   count_out_reg, count_out_next;
    logic                         ovf_out_reg, ovf_out_next;

    logic                         in_xfer;
    logic                         out_xfer;
    logic [SW-1:0]                cap;
    logic [LW-1:0]                idx_inc;
    logic [LW-1:0]                ja_inc;
    logic                         ram_we;
    logic [AW-1:0]                ram_raddr;
    logic [orec_pkg::ID_W-1:0]    ram_rdata;
    logic                         any_hit;
    logic                         any_open;
    logic                         scan_done;
    orec_pkg::cell_ctl_t          ctl;
    orec_pkg::cell_sts_t          sts [MAX_SLOTS];
    logic [MAX_SLOTS:0]           claim;
    logic [MAX_SLOTS-1:0]         hit_vec;
    logic [MAX_SLOTS-1:0]         open_vec;

    assign in_stall       = (state_reg != S_LOAD);
    assign in_xfer        = in_valid & ~in_stall;
    assign out_xfer       = out_valid_reg & ~out_stall;
    assign out_valid      = out_valid_reg;
    assign eviction_count = count_out_reg;
    assign overflow       = ovf_out_reg;
    assign idx_inc        = idx_reg + LW'(1);
    assign ja_inc         = ja_reg + LW'(1);

    // Clamp the configured slot count into 1..MAX_SLOTS
    always_comb
    begin
        if (cfg_reg == '0)
        begin
            cap = SW'(1);
        end
        else if (32'(cfg_reg) > 32'(MAX_SLOTS))
        begin
            cap = SW'(MAX_SLOTS);
        end
        else
        begin
            cap = SW'(32'(cfg_reg));
        end
    end

    // Request store
    assign ram_we    = in_xfer & (len_reg < LW'(SEQ_DEPTH));
    assign ram_raddr = (state_reg == S_SCAN) ? ja_reg[AW-1:0] : idx_reg[AW-1:0];

    orec_ram #(
        .WIDTH (orec_pkg::ID_W),
        .DEPTH (SEQ_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (len_reg[AW-1:0]),
        .wdata (item_id),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Slot chain; the victim token ripples from slot 0 upward
    assign claim[0] = 1'b1;

    for (genvar k = 0; k < MAX_SLOTS; k++)
    begin : g_cell
        orec_cell #(
            .SW  (SW),
            .IDX (k)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl),
            .fill_idx  (filled_reg),
            .claim_in  (claim[k]),
            .claim_out (claim[k+1]),
            .sts       (sts[k])
        );
        assign hit_vec[k]  = sts[k].hit;
        assign open_vec[k] = sts[k].open;
    end

    assign any_hit   = |hit_vec;
    assign any_open  = |open_vec;
    assign scan_done = dv_reg & (~any_open | dl_reg);

    // Sequencer next state and cell control
    always_comb
    begin
        state_next     = state_reg;
        len_next       = len_reg;
        ovf_next       = ovf_reg;
        idx_next       = idx_reg;
        ja_next        = ja_reg;
        dv_next        = 1'b0;
        dl_next        = 1'b0;
        filled_next    = filled_reg;
        evict_next     = evict_reg;
        cur_next       = cur_reg;
        out_valid_next = out_valid_reg & ~out_xfer;
        count_out_next = count_out_reg;
        ovf_out_next   = ovf_out_reg;

        ctl.restart    = 1'b0;
        ctl.scan_en    = 1'b0;
        ctl.fill_en    = 1'b0;
        ctl.evict_go   = 1'b0;
        ctl.all_found  = ~any_open;
        ctl.scan_id    = ram_rdata;
        ctl.cur_id     = (state_reg == S_CHECK) ? ram_rdata : cur_reg;

        unique case (state_reg)
            S_LOAD:
            begin
                // Store each request; drop and flag once the store is full
                if (in_xfer)
                begin
                    if (ram_we)
                    begin
                        len_next = len_reg + LW'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (last)
                    begin
                        ctl.restart = 1'b1;
                        idx_next    = '0;
                        filled_next = '0;
                        evict_next  = '0;
                        state_next  = S_FETCH;
                    end
                end
            end

            S_FETCH:
            begin
                state_next = S_CHECK;
            end

            S_CHECK:
            begin
                cur_next = ram_rdata;
                if (any_hit)
                begin
                    idx_next   = idx_inc;
                    state_next = (idx_inc == len_reg) ? S_DONE : S_FETCH;
                end
                else if (filled_reg < cap)
                begin
                    ctl.fill_en = 1'b1;
                    filled_next = filled_reg + SW'(1);
                    idx_next    = idx_inc;
                    state_next  = (idx_inc == len_reg) ? S_DONE : S_FETCH;
                end
                else if (idx_inc < len_reg)
                begin
                    // Look ahead for the next use of every slot
                    ja_next    = idx_inc;
                    state_next = S_SCAN;
                end
                else
                begin
                    // Final request: no slot is used again, take the lowest
                    ctl.evict_go = 1'b1;
                    evict_next   = evict_reg + orec_pkg::CNT_W'(1);
                    idx_next     = idx_inc;
                    state_next   = S_DONE;
                end
            end

            S_SCAN:
            begin
                // Issue the next look-ahead read
                if (ja_reg < len_reg)
                begin
                    ja_next = ja_inc;
                    dv_next = 1'b1;
                    dl_next = (ja_inc == len_reg);
                end
                ctl.scan_en = dv_reg;
                if (scan_done)
                begin
                    ctl.evict_go = 1'b1;
                    evict_next   = evict_reg + orec_pkg::CNT_W'(1);
                    idx_next     = idx_inc;
                    dv_next      = 1'b0;
                    state_next   = (idx_inc == len_reg) ? S_DONE : S_FETCH;
                end
            end

            S_DONE:
            begin
                // Place the result once the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    count_out_next = evict_reg;
                    ovf_out_next   = ovf_reg;
                    len_next       = '0;
                    ovf_next       = 1'b0;
                    state_next     = S_LOAD;
                end
            end

            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    // Hold state, counters and the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            cfg_reg       <= orec_pkg::CFG_W'(1);
            len_reg       <= '0;
            ovf_reg       <= 1'b0;
            idx_reg       <= '0;
            ja_reg        <= '0;
            dv_reg        <= 1'b0;
            dl_reg        <= 1'b0;
            filled_reg    <= '0;
            evict_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            if (cfg_we)
            begin
                cfg_reg <= cfg_data;
            end
            len_reg       <= len_next;
            ovf_reg       <= ovf_next;
            idx_reg       <= idx_next;
            ja_reg        <= ja_next;
            dv_reg        <= dv_next;
            dl_reg        <= dl_next;
            filled_reg    <= filled_next;
            evict_reg     <= evict_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cur_reg       <= cur_next;
        count_out_reg <= count_out_next;
        ovf_out_reg   <= ovf_out_next;
    end

endmodule
